// ===== src/iepf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_pkg: shared definitions for the ICMP echo parity filter
// Frame offsets of the parsed header fields, the length width and the
// verdict codes.
// ----------------------------------------------------------------------------
package iepf_pkg;

	localparam int LENGTH_BITS = 16;

	typedef logic [LENGTH_BITS-1:0] length_t;

	localparam length_t LEN_MAX       = {LENGTH_BITS{1'b1}};
	localparam length_t OFS_ETYPE_HI  = length_t'(12);
	localparam length_t OFS_ETYPE_LO  = length_t'(13);
	localparam length_t OFS_IP_PROTO  = length_t'(23);
	localparam length_t OFS_ICMP_TYPE = length_t'(34);
	localparam length_t OFS_SEQ_LO    = length_t'(41);
	localparam length_t MIN_DROP_LEN  = length_t'(42);

	localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
	localparam logic [7:0]  IP_PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;

	typedef enum logic {
		VERDICT_PASS = 1'b0,
		VERDICT_DROP = 1'b1
	} verdict_t;

endpackage

// ===== src/iepf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iepf_if: channel interfaces of the ICMP echo parity filter
// A byte stream channel for frames and a result channel for verdicts.
// ----------------------------------------------------------------------------
interface iepf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, output packet_byte, output last_byte, input ready);
	modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface iepf_result_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic [15:0] frame_length;
	logic [63:0] verdict_packets;
	logic [63:0] verdict_bytes;

	modport source (output valid, output verdict, output frame_length,
		output verdict_packets, output verdict_bytes, input ready);
	modport sink (input valid, input verdict, input frame_length,
		input verdict_packets, input verdict_bytes, output ready);
endinterface

// ===== src/icmp_echo_parity_filter_with_stats_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_parity_filter_with_stats_unit: ICMP echo parity filter
// Parses an Ethernet frame byte by byte, drops IPv4 ICMP echo requests with
// an even sequence number and keeps packet and byte counters per verdict.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle while frame.ready is high and
// emits one result beat per frame: the beat that carries last_byte loads the
// verdict and the saturated length into the decision stage, which then updates
// the 64-bit counters of that verdict into the output register. Frames of any
// length, down to a single byte, may follow each other without gaps; the only
// thing that slows intake is backpressure on the result channel, which reaches
// frame.ready through the two-entry decision/output pipeline.
module icmp_echo_parity_filter_with_stats_unit
	import iepf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	iepf_byte_if.sink            frame,
	iepf_result_if.source        result
);

	// Per-frame parse state.
	length_t     byte_offset_q;
	logic [15:0] ethertype_q;
	logic [7:0]  ip_protocol_q;
	logic [7:0]  icmp_type_q;
	logic        sequence_odd_q;

	logic [15:0] ethertype_d;
	logic [7:0]  ip_protocol_d;
	logic [7:0]  icmp_type_d;
	logic        sequence_odd_d;
	length_t     len_d;
	verdict_t    verdict_d;

	// Decision stage.
	logic        valid_s1;
	verdict_t    verdict_s1;
	length_t     len_s1;

	// Counters and output register.
	logic [63:0] packet_counts_q [2];
	logic [63:0] byte_totals_q [2];
	logic        out_valid_q;
	verdict_t    out_verdict_q;
	logic [15:0] out_length_q;
	logic [63:0] out_packets_q;
	logic [63:0] out_bytes_q;

	logic        accept;
	logic        s1_move;
	logic [63:0] packets_next;
	logic [63:0] bytes_next;

	assign s1_move     = valid_s1 && (!out_valid_q || result.ready);
	assign frame.ready = !valid_s1 || s1_move;
	assign accept      = frame.valid && frame.ready;

	// Capture the current byte before deciding, so a field in the last byte counts.
	always_comb begin
		ethertype_d    = ethertype_q;
		ip_protocol_d  = ip_protocol_q;
		icmp_type_d    = icmp_type_q;
		sequence_odd_d = sequence_odd_q;
		if (byte_offset_q == OFS_ETYPE_HI) begin
			ethertype_d[15:8] = frame.packet_byte;
		end
		if (byte_offset_q == OFS_ETYPE_LO) begin
			ethertype_d[7:0] = frame.packet_byte;
		end
		if (byte_offset_q == OFS_IP_PROTO) begin
			ip_protocol_d = frame.packet_byte;
		end
		if (byte_offset_q == OFS_ICMP_TYPE) begin
			icmp_type_d = frame.packet_byte;
		end
		if (byte_offset_q == OFS_SEQ_LO) begin
			sequence_odd_d = frame.packet_byte[0];
		end
		len_d = (byte_offset_q != LEN_MAX) ? byte_offset_q + length_t'(1) : LEN_MAX;
		if (len_d >= MIN_DROP_LEN && ethertype_d == ETYPE_IPV4
			&& ip_protocol_d == IP_PROTO_ICMP && icmp_type_d == ICMP_ECHO_REQ
			&& !sequence_odd_d) begin
			verdict_d = VERDICT_DROP;
		end else begin
			verdict_d = VERDICT_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q  <= '0;
			ethertype_q    <= '0;
			ip_protocol_q  <= '0;
			icmp_type_q    <= '0;
			sequence_odd_q <= 1'b0;
		end else if (accept) begin
			if (frame.last_byte) begin
				byte_offset_q  <= '0;
				ethertype_q    <= '0;
				ip_protocol_q  <= '0;
				icmp_type_q    <= '0;
				sequence_odd_q <= 1'b0;
			end else begin
				byte_offset_q  <= len_d;
				ethertype_q    <= ethertype_d;
				ip_protocol_q  <= ip_protocol_d;
				icmp_type_q    <= icmp_type_d;
				sequence_odd_q <= sequence_odd_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && frame.last_byte) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame.last_byte) begin
			verdict_s1 <= verdict_d;
			len_s1     <= len_d;
		end
	end

	assign packets_next = packet_counts_q[verdict_s1] + 64'd1;
	assign bytes_next   = byte_totals_q[verdict_s1] + 64'(len_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_counts_q[0] <= '0;
			packet_counts_q[1] <= '0;
			byte_totals_q[0]   <= '0;
			byte_totals_q[1]   <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (s1_move) begin
				packet_counts_q[verdict_s1] <= packets_next;
				byte_totals_q[verdict_s1]   <= bytes_next;
				out_valid_q                 <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_verdict_q <= verdict_s1;
			out_length_q  <= 16'(len_s1);
			out_packets_q <= packets_next;
			out_bytes_q   <= bytes_next;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.verdict         = logic'(out_verdict_q);
	assign result.frame_length    = out_length_q;
	assign result.verdict_packets = out_packets_q;
	assign result.verdict_bytes   = out_bytes_q;

endmodule

// ===== tb/icmp_echo_parity_filter_with_stats_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_echo_parity_filter_with_stats_unit_tb: self-checking frame filter bench
// Streams Ethernet frames into the filter one byte per beat. Most frames are
// ICMP echo requests with random sequence numbers and payload; the rest have
// broken headers, are cut short or are plain noise. A software parser in the
// bench predicts the verdict, the length and both per-verdict counters of
// every frame, and the results are checked in order. Both channels idle at
// random rates, and the result side holds off long enough to back up the
// frame channel.
// ----------------------------------------------------------------------------
module icmp_echo_parity_filter_with_stats_unit_tb;
	import iepf_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BYTES = 1400;
	localparam int RANDOM_FRAMES_MIN = 25;

	typedef logic [7:0] octet_t;

	typedef struct {
		octet_t data;
		logic   last;
		int     phase;
	} frame_beat_t;

	typedef struct {
		verdict_t    verdict;
		logic [15:0] frame_length;
		logic [63:0] verdict_packets;
		logic [63:0] verdict_bytes;
	} filter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iepf_byte_if   frame_ch ();
	iepf_result_if result_ch ();

	icmp_echo_parity_filter_with_stats_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Frames waiting to be sent, and the frame under construction.
	frame_beat_t pending_beats[$];
	octet_t      frame_buf[$];

	// Software copy of the parser and the counters.
	length_t     parse_offset;
	logic [15:0] seen_ethertype;
	octet_t      seen_protocol;
	octet_t      seen_icmp_type;
	logic        seen_seq_odd;
	logic [63:0] frames_per_verdict [2];
	logic [63:0] bytes_per_verdict [2];

	filter_result_t expected_results[$];

	int mismatches = 0;
	int frames_dropped = 0;
	int frames_passed = 0;
	int longest_frame = 0;
	int beats_taken = 0;
	int input_stalls = 0;

	int   cur_phase = 0;
	logic byte_taken = 1'b0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic advance_parser(input octet_t data, input logic last);
		length_t        pos;
		length_t        len;
		verdict_t       v;
		filter_result_t r;
		pos = parse_offset;
		if (pos == OFS_ETYPE_HI) begin
			seen_ethertype[15:8] = data;
		end else if (pos == OFS_ETYPE_LO) begin
			seen_ethertype[7:0] = data;
		end else if (pos == OFS_IP_PROTO) begin
			seen_protocol = data;
		end else if (pos == OFS_ICMP_TYPE) begin
			seen_icmp_type = data;
		end else if (pos == OFS_SEQ_LO) begin
			seen_seq_odd = data[0];
		end
		len = (pos < LEN_MAX) ? pos + length_t'(1) : LEN_MAX;
		if (!last) begin
			parse_offset = len;
		end else begin
			v = VERDICT_PASS;
			if (len >= MIN_DROP_LEN && seen_ethertype == ETYPE_IPV4 &&
					seen_protocol == IP_PROTO_ICMP && seen_icmp_type == ICMP_ECHO_REQ &&
					!seen_seq_odd) begin
				v = VERDICT_DROP;
			end
			frames_per_verdict[v] += 64'd1;
			bytes_per_verdict[v] += 64'(len);
			r.verdict = v;
			r.frame_length = 16'(len);
			r.verdict_packets = frames_per_verdict[v];
			r.verdict_bytes = bytes_per_verdict[v];
			expected_results.push_back(r);
			if (v == VERDICT_DROP) begin
				frames_dropped++;
			end else begin
				frames_passed++;
			end
			if (int'(len) > longest_frame) begin
				longest_frame = int'(len);
			end
			parse_offset = '0;
			seen_ethertype = '0;
			seen_protocol = '0;
			seen_icmp_type = '0;
			seen_seq_odd = 1'b0;
		end
	endtask

	// Fills frame_buf with random bytes and places the header fields that
	// fit inside the frame.
	task automatic make_frame(input int len, input logic [15:0] etype, input octet_t proto,
		input octet_t icmp, input octet_t seq_lo);
		frame_buf.delete();
		for (int i = 0; i < len; i++) begin
			frame_buf.push_back(octet_t'($urandom_range(0, 255)));
		end
		if (len > 12) frame_buf[12] = etype[15:8];
		if (len > 13) frame_buf[13] = etype[7:0];
		if (len > 23) frame_buf[23] = proto;
		if (len > 34) frame_buf[34] = icmp;
		if (len > 41) frame_buf[41] = seq_lo;
	endtask

	task automatic queue_frame(input int phase);
		frame_beat_t beat;
		for (int i = 0; i < frame_buf.size(); i++) begin
			beat.data = frame_buf[i];
			beat.last = (i == frame_buf.size() - 1);
			beat.phase = phase;
			pending_beats.push_back(beat);
		end
	endtask

	// Sender: a beat stays on the channel until it is taken.
	always @(negedge clk) begin : frame_driver
		int idle_pct;
		if (arst_n && (!frame_ch.valid || byte_taken)) begin
			if (pending_beats.size() != 0) begin
				idle_pct = (pending_beats[0].phase == 0) ? 34 :
					(pending_beats[0].phase == 1) ? 49 : 0;
			end else begin
				idle_pct = 100;
			end
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				frame_ch.valid <= 1'b1;
				frame_ch.packet_byte <= pending_beats[0].data;
				frame_ch.last_byte <= pending_beats[0].last;
				cur_phase <= pending_beats[0].phase;
				void'(pending_beats.pop_front());
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	// The long hold-off starts once, at the first beat of the phase without
	// idling, so the filter pipeline fills and stalls the frame channel.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (arst_n && !hold_done && cur_phase == 2) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin : result_receiver
		int idle_pct;
		idle_pct = (cur_phase == 0) ? 49 : (cur_phase == 1) ? 34 : 0;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin : stream_monitor
		filter_result_t want;
		byte_taken <= frame_ch.valid && frame_ch.ready;
		if (frame_ch.valid && !frame_ch.ready) begin
			input_stalls++;
		end
		if (frame_ch.valid && frame_ch.ready) begin
			beats_taken++;
			advance_parser(frame_ch.packet_byte, frame_ch.last_byte);
		end
		if (result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing expected, verdict",
					64'(result_ch.verdict), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result_ch.verdict !== want.verdict)
					report_mismatch("verdict", 64'(result_ch.verdict), 64'(want.verdict));
				if (result_ch.frame_length !== want.frame_length)
					report_mismatch("frame_length", 64'(result_ch.frame_length),
						64'(want.frame_length));
				if (result_ch.verdict_packets !== want.verdict_packets)
					report_mismatch("verdict_packets", result_ch.verdict_packets,
						want.verdict_packets);
				if (result_ch.verdict_bytes !== want.verdict_bytes)
					report_mismatch("verdict_bytes", result_ch.verdict_bytes,
						want.verdict_bytes);
			end
		end
	end

	initial begin
		#(CLK_PERIOD * 2000000);
		$display("icmp_echo_parity_filter_with_stats_unit_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		int random_bytes;
		int random_frames;
		int phase;
		int kind;
		int len;
		logic [15:0] etype;
		octet_t proto;
		octet_t icmp;

		frame_ch.valid = 1'b0;
		frame_ch.packet_byte = '0;
		frame_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;

		parse_offset = '0;
		seen_ethertype = '0;
		seen_protocol = '0;
		seen_icmp_type = '0;
		seen_seq_odd = 1'b0;
		for (int i = 0; i < 2; i++) begin
			frames_per_verdict[i] = '0;
			bytes_per_verdict[i] = '0;
		end

		// Directed frames: two single-byte frames in a row, echo requests
		// right at and just under the drop length, each header field wrong
		// in turn, headers cut off at each field, and all-ones/all-zeros.
		make_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00);
		frame_buf[0] = 8'hFF;
		queue_frame(0);
		make_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00);
		frame_buf[0] = 8'h00;
		queue_frame(0);
		make_frame(42, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(42, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h01);
		queue_frame(0);
		make_frame(41, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(42, 16'h0801, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(42, 16'h8800, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(42, ETYPE_IPV4, 8'h06, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(42, ETYPE_IPV4, IP_PROTO_ICMP, 8'h00, 8'h00);
		queue_frame(0);
		make_frame(13, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(24, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(35, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h00);
		queue_frame(0);
		make_frame(64, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'hFE);
		queue_frame(0);
		make_frame(60, 16'h0000, 8'h00, 8'h00, 8'h00);
		foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
		queue_frame(0);
		make_frame(60, 16'h0000, 8'h00, 8'h00, 8'h00);
		foreach (frame_buf[i]) frame_buf[i] = 8'h00;
		queue_frame(0);

		// Random frames: mostly well-formed echo requests with a random
		// sequence number, some with one broken field and some plain noise.
		random_bytes = 0;
		random_frames = 0;
		while (random_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES_MIN) begin
			phase = (random_bytes < RANDOM_BYTES / 3) ? 0 :
				(random_bytes < 2 * RANDOM_BYTES / 3) ? 1 : 2;
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(42, 72) : $urandom_range(30, 45);
			etype = ETYPE_IPV4;
			proto = IP_PROTO_ICMP;
			icmp = ICMP_ECHO_REQ;
			if (kind >= 70 && kind < 85) begin
				case ($urandom_range(0, 2))
					0: etype = 16'($urandom_range(0, 65535));
					1: proto = octet_t'($urandom_range(0, 255));
					default: icmp = octet_t'($urandom_range(0, 255));
				endcase
			end
			make_frame(len, etype, proto, icmp, octet_t'($urandom_range(0, 255)));
			if (kind >= 85) begin
				make_frame($urandom_range(1, 64), 16'($urandom_range(0, 65535)),
					octet_t'($urandom_range(0, 255)), octet_t'($urandom_range(0, 255)),
					octet_t'($urandom_range(0, 255)));
			end
			queue_frame(phase);
			random_bytes += frame_buf.size();
			random_frames++;
		end

		// A last echo request and a single-byte frame with no idling.
		make_frame(42, ETYPE_IPV4, IP_PROTO_ICMP, ICMP_ECHO_REQ, 8'h02);
		queue_frame(2);
		make_frame(1, 16'h0000, 8'h00, 8'h00, 8'h00);
		queue_frame(2);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || frame_ch.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d frames (%0d dropped, %0d passed), longest %0d bytes.",
			beats_taken, frames_dropped + frames_passed, frames_dropped, frames_passed,
			longest_frame);
		$display("The frame channel was held back for %0d cycles; %0d mismatches.",
			input_stalls, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("icmp_echo_parity_filter_with_stats_unit_tb OK");
		end else begin
			$display("icmp_echo_parity_filter_with_stats_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
